// ===== hdl/b64enc_pkg.sv =====
// Shared types, constants and the symbol lookup for the base64 stream encoder.
package b64enc_pkg;

   localparam logic [7:0] PadChar     = 8'h3d;
   localparam logic [7:0] NewlineChar = 8'h0a;
   localparam logic [7:0] PlusChar    = 8'h2b;
   localparam logic [7:0] SlashChar   = 8'h2f;

   localparam logic [2:0] CharIdxFirst   = 3'd0;
   localparam logic [2:0] CharIdxSecond  = 3'd1;
   localparam logic [2:0] CharIdxThird   = 3'd2;
   localparam logic [2:0] CharIdxFourth  = 3'd3;
   localparam logic [2:0] CharIdxNewline = 3'd4;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] nbytes;
      logic       last;
      logic       newline;
   } group_type;

   function automatic logic [7:0] symbol(input logic [5:0] v);
      logic [7:0] r;
      begin
         if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
         end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
         end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
         end else if (v == 6'd62) begin
            r = PlusChar;
         end else begin
            r = SlashChar;
         end
         return r;
      end
   endfunction

endpackage

// ===== hdl/b64enc_front.sv =====
// Front end: collects input bytes into groups of up to three and hands them on.
module b64enc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   newline_enable,
   input  logic                   q_ready,
   output logic                   q_push,
   output b64enc_pkg::group_type  q_entry
);

   logic [1:0] count_ff, count_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   logic       complete;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;
   assign complete   = req_tlast || (count_ff == 2'd2);
   assign q_push     = accept && complete;

   always_comb begin
      q_entry         = '0;
      q_entry.nbytes  = count_ff + 2'd1;
      q_entry.last    = req_tlast;
      q_entry.newline = newline_enable;
      unique case (count_ff)
         2'd0: begin
            q_entry.byte0 = req_tdata;
         end
         2'd1: begin
            q_entry.byte0 = pend0_ff;
            q_entry.byte1 = req_tdata;
         end
         default: begin
            q_entry.byte0 = pend0_ff;
            q_entry.byte1 = pend1_ff;
            q_entry.byte2 = req_tdata;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (accept) begin
         if (complete) begin
            count_in = 2'd0;
         end else begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               pend0_in = req_tdata;
            end else begin
               pend1_in = req_tdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

// ===== hdl/b64enc_queue.sv =====
// Two-entry queue of byte groups between the front and back ends.
module b64enc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  b64enc_pkg::group_type  push_entry,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   pop_valid,
   output b64enc_pkg::group_type  pop_entry
);

   b64enc_pkg::group_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/b64enc_back.sv =====
// Back end: turns one byte group into characters, one per beat, through an output register.
module b64enc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  b64enc_pkg::group_type  q_entry,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   logic                  busy_ff, busy_in;
   b64enc_pkg::group_type ent_ff, ent_in;
   logic [2:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            data_ff, data_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic                  at_end;
   logic [2:0]            end_idx;
   logic [23:0]           word;
   logic [7:0]            char_now;

   assign word    = {ent_ff.byte0, ent_ff.byte1, ent_ff.byte2};
   assign end_idx = (ent_ff.last && ent_ff.newline) ? b64enc_pkg::CharIdxNewline
                                                    : b64enc_pkg::CharIdxFourth;
   assign at_end  = (idx_ff == end_idx);
   assign load    = busy_ff && (!valid_ff || rsp_tready);
   assign q_pop   = q_valid && (!busy_ff || (load && at_end));

   always_comb begin
      unique case (idx_ff)
         b64enc_pkg::CharIdxFirst:  char_now = b64enc_pkg::symbol(word[23:18]);
         b64enc_pkg::CharIdxSecond: char_now = b64enc_pkg::symbol(word[17:12]);
         b64enc_pkg::CharIdxThird:
            char_now = (ent_ff.nbytes >= 2'd2) ? b64enc_pkg::symbol(word[11:6])
                                               : b64enc_pkg::PadChar;
         b64enc_pkg::CharIdxFourth:
            char_now = (ent_ff.nbytes >= 2'd3) ? b64enc_pkg::symbol(word[5:0])
                                               : b64enc_pkg::PadChar;
         default:                   char_now = b64enc_pkg::NewlineChar;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      ent_in   = ent_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         ent_in  = q_entry;
         idx_in  = b64enc_pkg::CharIdxFirst;
      end else if (load && at_end) begin
         busy_in = 1'b0;
      end else if (load) begin
         idx_in = idx_ff + 3'd1;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = char_now;
         last_in  = at_end && ent_ff.last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      ent_ff  <= ent_in;
      idx_ff  <= idx_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hdl/base64_stream_encoder_core.sv =====
// Top level of the base64 stream encoder: front end, group queue, back end, option register.
//
//  channel | direction | tdata            | tlast
//  req     | in        | [7:0] data_byte  | last_byte
//  rsp     | out       | [7:0] out_char   | out_last
//  csr     | in        | csr_wr_data = newline_enable, written when csr_wr_en
//
//  A byte is taken each cycle while the two-entry group queue has room.
//  Each group leaves as four characters (five with the newline), one per cycle through
//  the output register while rsp is not stalled.
//  A completing byte goes through a queue slot, the group register and the output register.
//  Synchronous reset clears byte count, queue state, busy and valid; newline_enable resets to 1.
//  An rsp stall holds the current character and backs up into the queue and req.
module base64_stream_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                  newline_ff, newline_in;
   logic                  q_ready;
   logic                  q_push;
   b64enc_pkg::group_type push_entry;
   logic                  q_pop;
   logic                  q_valid;
   b64enc_pkg::group_type pop_entry;

   assign newline_in = csr_wr_en ? csr_wr_data : newline_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         newline_ff <= 1'b1;
      end else begin
         newline_ff <= newline_in;
      end
   end

   b64enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .newline_enable (newline_ff),
      .q_ready        (q_ready),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   b64enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/b64enc_checker.sv =====
// Port-level checks for the base64 stream encoder, bound to the top level.
module b64enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_wr_en,
   input logic       csr_wr_data
);

   logic nl_ff, nl_in;
   logic rsp_beat;

   assign nl_in    = csr_wr_en ? csr_wr_data : nl_ff;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nl_ff <= 1'b1;
      end else begin
         nl_ff <= nl_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tlast && nl_ff |-> rsp_tdata == b64enc_pkg::NewlineChar)
      else $error("final beat is not a newline with newline enabled");

   a_newline_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tdata == b64enc_pkg::NewlineChar |-> rsp_tlast && nl_ff)
      else $error("newline outside final beat");

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the base64 stream encoder core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [511:0] Base64Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // {last_byte, data_byte}
   localparam int DirectedCount = 22;
   localparam int NewlineOffAt  = 16;
   localparam logic [8:0] DirectedBeats [DirectedCount] = '{
      {1'b1, 8'h00}, {1'b1, 8'hff},
      {1'b0, 8'hfb}, {1'b0, 8'hef}, {1'b1, 8'hbe},
      {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b1, 8'h00},
      {1'b0, 8'h4d}, {1'b1, 8'h61},
      {1'b0, 8'h00}, {1'b0, 8'hff}, {1'b0, 8'h55}, {1'b0, 8'haa}, {1'b1, 8'h01},
      {1'b1, 8'h01},
      {1'b0, 8'h7f}, {1'b1, 8'hfe},
      {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b1, 8'h56}
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   class b64_scoreboard_type;
      enc_char_type expected_chars[$];
      logic        newline_on;
      logic [7:0]  held_bytes [2];
      int unsigned held_count;
      int unsigned errors;
      int unsigned bytes_seen;
      int unsigned chars_checked;
      int unsigned messages;
      int unsigned newline_writes;

      function new();
         newline_on = 1'b1;
         held_count = 0;
         errors = 0;
         bytes_seen = 0;
         chars_checked = 0;
         messages = 0;
         newline_writes = 0;
      endfunction

      static function logic [7:0] sextet_char(input logic [5:0] v);
         int idx;
         idx = v;
         return Base64Alphabet[511 - 8 * idx -: 8];
      endfunction

      function void set_newline(input logic v);
         newline_on = v;
         newline_writes++;
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      function void note_byte(input logic [7:0] data, input logic last);
         logic [23:0] word;
         logic [7:0]  sym [4];
         int          nbytes;
         bytes_seen++;
         if (!last && held_count < 2) begin
            held_bytes[held_count] = data;
            held_count++;
            return;
         end
         word = 24'h0;
         if (held_count > 0) word[23:16] = held_bytes[0];
         if (held_count > 1) word[15:8] = held_bytes[1];
         word[23 - 8 * held_count -: 8] = data;
         nbytes = held_count + 1;
         held_count = 0;
         for (int i = 0; i < 4; i++) begin
            sym[i] = sextet_char(word[23 - 6 * i -: 6]);
         end
         if (nbytes < 2) sym[2] = b64enc_pkg::PadChar;
         if (nbytes < 3) sym[3] = b64enc_pkg::PadChar;
         for (int i = 0; i < 4; i++) begin
            expected_chars.push_back('{ch: sym[i], last: (last && !newline_on && i == 3)});
         end
         if (last && newline_on) begin
            expected_chars.push_back('{ch: b64enc_pkg::NewlineChar, last: 1'b1});
         end
         if (last) messages++;
      endfunction

      function void check_char(input logic [7:0] ch, input logic last);
         enc_char_type want;
         if (expected_chars.size() == 0) begin
            $error("out_char: expected none, actual %02h (out_last %0b)", ch, last);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         chars_checked++;
         if (ch !== want.ch) begin
            $error("out_char: expected %02h, actual %02h", want.ch, ch);
            errors++;
         end
         if (last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, last);
            errors++;
         end
      endfunction

      function void check_drained();
         if (expected_chars.size() != 0) begin
            $error("out_char: %0d expected characters never arrived", expected_chars.size());
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic       rsp_tlast;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   int unsigned req_idle_pct = 26;
   int unsigned rsp_idle_pct = 72;
   b64_scoreboard_type sb;

   base64_stream_encoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_newline(csr_wr_data);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_char(rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_newline(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_message(output int len);
      logic [7:0] data;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0: data = 8'h00;
            1: data = 8'hff;
            default: data = 8'($urandom);
         endcase
         send_byte(data, i == len - 1);
      end
   endtask

   task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                            input int items, input logic first_newline);
      int sent;
      int len;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      settle();
      write_newline(first_newline);
      sent = 0;
      while (sent < items / 2) begin
         send_message(len);
         sent += len;
      end
      settle();
      write_newline(!first_newline);
      while (sent < items) begin
         send_message(len);
         sent += len;
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirectedCount; i++) begin
         if (i == NewlineOffAt) begin
            settle();
            write_newline(1'b0);
         end
         send_byte(DirectedBeats[i][7:0], DirectedBeats[i][8]);
      end

      run_phase(26, 72, 124, 1'b1);
      run_phase(72, 26, 124, 1'b0);
      run_phase(0, 0, 124, 1'b1);
      settle();
      sb.check_drained();

      $display("Encoded %0d messages from %0d bytes, %0d characters checked.",
               sb.messages, sb.bytes_seen, sb.chars_checked);
      $display("Newline option rewritten %0d times across three idle mixes.",
               sb.newline_writes);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== base64_stream_encoder_core.f =====
hdl/b64enc_pkg.sv
hdl/b64enc_front.sv
hdl/b64enc_queue.sv
hdl/b64enc_back.sv
hdl/base64_stream_encoder_core.sv
hdl/b64enc_checker.sv
tb/tb_top.sv
